// ===== rtl/core/sensor_thp_compensation_unit_assert.svh =====
// Assertion macros for the compensation unit.
// Included by the top level; needs clk and rst_n in scope.
`ifndef SENSOR_THP_COMPENSATION_UNIT_ASSERT_SVH
`define SENSOR_THP_COMPENSATION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define STHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sthp assertion failed");
`define STHP_NEVER(lbl, cond) `STHP_ASSERT(lbl, !(cond))
`else
`define STHP_ASSERT(lbl, prop)
`define STHP_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/core/sthp_pkg.sv =====
// Shared types, codes and helpers for the compensation unit.
// No dependencies.
`timescale 1ns / 1ps
package sthp_pkg;
  typedef logic [31:0] word_t;
  typedef logic [47:0] cal_t;

  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MUL_STEPS = 32 / DIGIT_W;
  localparam int unsigned DIV_STEPS = 32;

  typedef enum logic [1:0] {
    FUNC_TEMP  = 2'd0,
    FUNC_PRESS = 2'd1,
    FUNC_HUM   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_TEMP_CAL    = 3'd0,
    REG_PRESS_FIRST = 3'd1,
    REG_PRESS_MID   = 3'd2,
    REG_PRESS_LAST  = 3'd3,
    REG_HUM_FIRST   = 3'd4,
    REG_HUM_SECOND  = 3'd5
  } cfg_idx_t;

  // handshake status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic word_t asr(word_t x, int unsigned n);
    return word_t'($signed(x) >>> n);
  endfunction

  function automatic word_t sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic word_t sx8(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction
endpackage

// ===== rtl/core/sthp_in_if.sv =====
// Input channel: selector and raw reading.
// Depends on nothing.
`timescale 1ns / 1ps
interface sthp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [19:0] raw_reading;
  modport source (output valid, func, raw_reading, input ready);
  modport sink (input valid, func, raw_reading, output ready);
endinterface

// ===== rtl/core/sthp_out_if.sv =====
// Result channel: compensated value and zero divisor flag.
// Depends on nothing.
`timescale 1ns / 1ps
interface sthp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] compensated;
  logic        zero_divisor;
  modport source (output valid, compensated, zero_divisor, input ready);
  modport sink (input valid, compensated, zero_divisor, output ready);
endinterface

// ===== rtl/core/sthp_cfg_if.sv =====
// Configuration write channel: register index and data.
// Depends on nothing.
`timescale 1ns / 1ps
interface sthp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sthp_mul.sv =====
// Digit-serial multiplier, low 32 bits of a 32x32 product, one digit per cycle.
// Depends on sthp_pkg.
`timescale 1ns / 1ps
module sthp_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sthp_pkg::word_t     a,
  input  sthp_pkg::word_t     b,
  output sthp_pkg::word_t     prod,
  output sthp_pkg::unit_stat_t stat
);
  import sthp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MUL_STEPS);

  word_t            acc_r, a_r, b_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        a_r    <= a;
        b_r    <= b;
      end else if (busy_r) begin
        acc_r <= acc_r + word_t'(a_r * {{(32-DIGIT_W){1'b0}}, b_r[DIGIT_W-1:0]});
        a_r   <= a_r << DIGIT_W;
        b_r   <= b_r >> DIGIT_W;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

// ===== rtl/core/sthp_div.sv =====
// Bit-serial restoring divider, unsigned 32 by 32, one quotient bit per cycle.
// Depends on sthp_pkg.
`timescale 1ns / 1ps
module sthp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  sthp_pkg::word_t     dividend,
  input  sthp_pkg::word_t     divisor,
  output sthp_pkg::word_t     quot,
  output sthp_pkg::unit_stat_t stat
);
  import sthp_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  word_t            rem_r, quo_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [32:0]      rem_sh, diff;

  assign rem_sh = {rem_r, quo_r[31]};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        den_r  <= divisor;
      end else if (busy_r) begin
        if (!diff[32]) begin
          rem_r <= diff[31:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh[31:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot      = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule

// ===== rtl/core/sensor_thp_compensation_unit.sv =====
// Temperature / pressure / humidity compensation unit, top level.
// Depends on sthp_pkg, the three channel interfaces, sthp_mul, sthp_div.
//
// Usage:
//   cfg_if  : calibration writes (index 0..5), always ready, taken at
//             valid && ready. Writes to indexes 6 and 7 are dropped.
//             Write only while the unit is idle.
//   in_if   : one item = selector + raw reading, taken when the unit is
//             idle (ready high in the idle state only).
//   out_if  : one result per item, held in an output register until taken.
// Operation: every formula runs as a short sequence of steps on one shared
//   4-bit-digit serial multiplier plus one bit-serial divider for pressure;
//   selector 3 runs no steps. The result becomes valid in the same cycle
//   as the unit returns to idle and can take the next item.
// Reset (rst_n low, synchronous) clears calibration words, the stored
//   fine temperature and all control state.
// Stall: a new item is taken while a result still waits; its last step
//   then holds until the output register frees up.
`timescale 1ns / 1ps
module sensor_thp_compensation_unit (
  input  logic       clk,
  input  logic       rst_n,
  sthp_cfg_if.sink   cfg_if,
  sthp_in_if.sink    in_if,
  sthp_out_if.source out_if
);
  import sthp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  // calibration registers
  cal_t  tcal_r, pcal1_r, pcal2_r, pcal3_r;
  word_t hcal1_r, hcal2_r;
  word_t ft_r, ft_nxt;

  state_t      st_r;
  logic [3:0]  step_r;
  func_t       func_r;
  logic [19:0] adc_r;
  word_t       r1_r, r2_r, r3_r, r4_r, r5_r;
  word_t       r1_nxt, r2_nxt, r3_nxt, r4_nxt, r5_nxt;
  word_t       res_r;
  logic        zero_r;
  logic        out_valid_r;

  // step decode outputs
  logic  issue_mul, issue_div, finish, zflag;
  word_t mul_a, mul_b, div_n, res;

  word_t      prod, quot;
  unit_stat_t mul_stat, div_stat;

  // calibration fields
  word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  word_t h1, h2, h3, h4, h5, h6, adc;
  assign t1  = {16'd0, tcal_r[15:0]};
  assign t2  = sx16(tcal_r[31:16]);
  assign t3  = sx16(tcal_r[47:32]);
  assign p1  = {16'd0, pcal1_r[15:0]};
  assign p2  = sx16(pcal1_r[31:16]);
  assign p3  = sx16(pcal1_r[47:32]);
  assign p4  = sx16(pcal2_r[15:0]);
  assign p5  = sx16(pcal2_r[31:16]);
  assign p6  = sx16(pcal2_r[47:32]);
  assign p7  = sx16(pcal3_r[15:0]);
  assign p8  = sx16(pcal3_r[31:16]);
  assign p9  = sx16(pcal3_r[47:32]);
  assign h1  = {24'd0, hcal1_r[7:0]};
  assign h2  = sx16(hcal1_r[23:8]);
  assign h3  = {24'd0, hcal1_r[31:24]};
  assign h4  = {20'd0, hcal2_r[11:0]};
  assign h5  = {20'd0, hcal2_r[23:12]};
  assign h6  = sx8(hcal2_r[31:24]);
  assign adc = {12'd0, adc_r};

  // scratch values used by the steps
  word_t ft_h, q_t, ftn, p5v, pq, hv, hval, v1b;
  assign ft_h = asr(ft_r, 1) - 32'd64000;
  assign q_t  = asr(ft_h, 2);
  assign ftn  = r1_r + asr(prod, 14);
  assign v1b  = asr(r2_r + asr(prod, 1), 18);
  assign pq   = r5_r[31] ? {quot[30:0], 1'b0} : quot;
  assign p5v  = asr(prod + 32'd8192, 14);
  assign hv   = ft_r - 32'd76800;
  assign hval = r4_r - asr(prod, 4);

  always_comb begin
    issue_mul = 1'b0;
    issue_div = 1'b0;
    finish    = 1'b0;
    zflag     = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_n     = '0;
    res       = '0;
    ft_nxt    = ft_r;
    r1_nxt    = r1_r;
    r2_nxt    = r2_r;
    r3_nxt    = r3_r;
    r4_nxt    = r4_r;
    r5_nxt    = r5_r;
    case (func_r)
      FUNC_TEMP: begin
        case (step_r)
          4'd0: begin
            issue_mul = 1'b1;
            mul_a = {15'd0, adc_r[19:3]} - {t1[30:0], 1'b0};
            mul_b = t2;
          end
          4'd1: begin
            r1_nxt = asr(prod, 11);
            issue_mul = 1'b1;
            mul_a = {16'd0, adc_r[19:4]} - t1;
            mul_b = {16'd0, adc_r[19:4]} - t1;
          end
          4'd2: begin
            issue_mul = 1'b1;
            mul_a = asr(prod, 12);
            mul_b = t3;
          end
          default: begin
            ft_nxt = ftn;
            finish = 1'b1;
            res    = asr({ftn[29:0], 2'b00} + ftn + 32'd128, 8);
          end
        endcase
      end
      FUNC_PRESS: begin
        case (step_r)
          4'd0: begin
            r1_nxt = ft_h;
            issue_mul = 1'b1;
            mul_a = q_t;
            mul_b = q_t;
          end
          4'd1: begin
            r2_nxt = prod;
            issue_mul = 1'b1;
            mul_a = asr(prod, 11);
            mul_b = p6;
          end
          4'd2: begin
            r3_nxt = prod;
            issue_mul = 1'b1;
            mul_a = r1_r;
            mul_b = p5;
          end
          4'd3: begin
            r3_nxt = asr(r3_r + {prod[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
            issue_mul = 1'b1;
            mul_a = p3;
            mul_b = asr(r2_r, 13);
          end
          4'd4: begin
            r2_nxt = asr(prod, 3);
            issue_mul = 1'b1;
            mul_a = p2;
            mul_b = r1_r;
          end
          4'd5: begin
            issue_mul = 1'b1;
            mul_a = 32'd32768 + v1b;
            mul_b = p1;
          end
          4'd6: begin
            r4_nxt = asr(prod, 15);
            if (asr(prod, 15) == '0) begin
              // divisor zero: result forced to 0
              finish = 1'b1;
              zflag  = 1'b1;
            end else begin
              issue_mul = 1'b1;
              mul_a = (32'd1048576 - adc) - asr(r3_r, 12);
              mul_b = 32'd3125;
            end
          end
          4'd7: begin
            r5_nxt = prod;
            issue_div = 1'b1;
            div_n = prod[31] ? prod : {prod[30:0], 1'b0};
          end
          4'd8: begin
            r5_nxt = pq;
            issue_mul = 1'b1;
            mul_a = pq >> 3;
            mul_b = pq >> 3;
          end
          4'd9: begin
            issue_mul = 1'b1;
            mul_a = p9;
            mul_b = prod >> 13;
          end
          4'd10: begin
            r1_nxt = asr(prod, 12);
            issue_mul = 1'b1;
            mul_a = r5_r >> 2;
            mul_b = p8;
          end
          default: begin
            finish = 1'b1;
            res    = r5_r + asr(r1_r + asr(prod, 13) + p7, 4);
          end
        endcase
      end
      FUNC_HUM: begin
        case (step_r)
          4'd0: begin
            r1_nxt = hv;
            issue_mul = 1'b1;
            mul_a = h5;
            mul_b = hv;
          end
          4'd1: begin
            r2_nxt = asr({adc_r[17:0], 14'd0} - {h4[11:0], 20'd0} - prod
                         + 32'd16384, 15);
            issue_mul = 1'b1;
            mul_a = r1_r;
            mul_b = h6;
          end
          4'd2: begin
            r3_nxt = prod;
            issue_mul = 1'b1;
            mul_a = r1_r;
            mul_b = h3;
          end
          4'd3: begin
            issue_mul = 1'b1;
            mul_a = asr(r3_r, 10);
            mul_b = asr(prod, 11) + 32'd32768;
          end
          4'd4: begin
            issue_mul = 1'b1;
            mul_a = asr(prod, 10) + 32'd2097152;
            mul_b = h2;
          end
          4'd5: begin
            issue_mul = 1'b1;
            mul_a = r2_r;
            mul_b = p5v;
          end
          4'd6: begin
            r4_nxt = prod;
            issue_mul = 1'b1;
            mul_a = asr(prod, 15);
            mul_b = asr(prod, 15);
          end
          4'd7: begin
            issue_mul = 1'b1;
            mul_a = asr(prod, 7);
            mul_b = h1;
          end
          default: begin
            finish = 1'b1;
            // clamp to 0..100 percent before dropping the low 12 fraction bits
            if (hval[31])
              res = '0;
            else if (hval > 32'd419430400)
              res = 32'd419430400 >> 12;
            else
              res = hval >> 12;
          end
        endcase
      end
      default: begin
        finish = 1'b1;
      end
    endcase
  end

  logic out_free, run, advance;
  assign out_free = !out_valid_r || out_if.ready;
  assign run      = (st_r == S_RUN);
  assign advance  = run && (!finish || out_free);

  sthp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (advance && issue_mul),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .stat  (mul_stat)
  );

  sthp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (advance && issue_div),
    .dividend (div_n),
    .divisor  (r4_r),
    .quot     (quot),
    .stat     (div_stat)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r  <= '0;
      pcal1_r <= '0;
      pcal2_r <= '0;
      pcal3_r <= '0;
      hcal1_r <= '0;
      hcal2_r <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_idx_t'(cfg_if.index))
        REG_TEMP_CAL:    tcal_r  <= cfg_if.data;
        REG_PRESS_FIRST: pcal1_r <= cfg_if.data;
        REG_PRESS_MID:   pcal2_r <= cfg_if.data;
        REG_PRESS_LAST:  pcal3_r <= cfg_if.data;
        REG_HUM_FIRST:   hcal1_r <= cfg_if.data[31:0];
        REG_HUM_SECOND:  hcal2_r <= cfg_if.data[31:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      step_r      <= '0;
      ft_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a result taken in the same cycle as a new one lands stays valid
      if (out_valid_r && out_if.ready && !(advance && finish))
        out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_if.valid) begin
            func_r <= func_t'(in_if.func);
            adc_r  <= in_if.raw_reading;
            step_r <= '0;
            st_r   <= S_RUN;
          end
        end
        S_RUN: begin
          if (advance) begin
            ft_r <= ft_nxt;
            r1_r <= r1_nxt;
            r2_r <= r2_nxt;
            r3_r <= r3_nxt;
            r4_r <= r4_nxt;
            r5_r <= r5_nxt;
            if (finish) begin
              res_r       <= res;
              zero_r      <= zflag;
              out_valid_r <= 1'b1;
              st_r        <= S_IDLE;
            end else begin
              st_r <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (mul_stat.done || div_stat.done) begin
            step_r <= step_r + 1'b1;
            st_r   <= S_RUN;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_if.ready        = 1'b1;
  assign in_if.ready         = (st_r == S_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.compensated  = res_r;
  assign out_if.zero_divisor = zero_r;

`include "sensor_thp_compensation_unit_assert.svh"

  `STHP_NEVER(a_units_idle_when_ready, in_if.ready && (mul_stat.busy || div_stat.busy))
  `STHP_NEVER(a_one_unit_busy, mul_stat.busy && div_stat.busy)
  `STHP_ASSERT(a_zero_flag_value, out_if.valid && out_if.zero_divisor |-> out_if.compensated == 32'd0)
  `STHP_ASSERT(a_accept_blocks, in_if.valid && in_if.ready |=> !in_if.ready)

endmodule

// ===== dv/sthp_tb_if.sv =====
// Testbench-side note: the channel interfaces come from the RTL tree.
// This file holds a small package of testbench types; depends on sthp_pkg.
`timescale 1ns / 1ps
package sthp_tb_pkg;
  import sthp_pkg::*;

  typedef struct packed {
    func_t       func;
    logic [19:0] raw;
  } reading_t;

  typedef struct packed {
    logic [31:0] value;
    logic        zdiv;
  } comp_t;
endpackage

// ===== dv/tb_sensor_thp_compensation_unit.sv =====
// Self-checking testbench for sensor_thp_compensation_unit.
// Drives readings through the handshake channels with random gaps and stalls and
// checks every result against an in-bench fixed-point model. Depends on sthp_pkg.
`timescale 1ns / 1ps
module tb_sensor_thp_compensation_unit;
  import sthp_pkg::*;
  import sthp_tb_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int SETTLE   = 200;  // longest item is pressure

  logic clk = 0;
  logic rst_n = 0;

  sthp_cfg_if cfg_if ();
  sthp_in_if  in_if ();
  sthp_out_if out_if ();

  sensor_thp_compensation_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_if(cfg_if), .in_if(in_if), .out_if(out_if)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: calibration copy and fine temperature.
  // ---------------------------------------------------------------------
  logic [47:0] cal_regs [6];
  logic [31:0] t_fine;

  reading_t pending_readings [$];
  comp_t    expected_comps [$];

  int errors = 0;
  int n_temp = 0, n_press = 0, n_hum = 0, n_none = 0, n_zdiv = 0, n_results = 0;

  function automatic logic [31:0] sar(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic comp_t compensate(reading_t r);
    comp_t c;
    logic [31:0] adc, t1, t2, t3, d, v1, v2, q, p;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, a, b, s;
    adc = {12'd0, r.raw};
    c.value = '0;
    c.zdiv = 1'b0;
    case (r.func)
      FUNC_TEMP: begin
        t1 = {16'd0, cal_regs[REG_TEMP_CAL][15:0]};
        t2 = sext16(cal_regs[REG_TEMP_CAL][31:16]);
        t3 = sext16(cal_regs[REG_TEMP_CAL][47:32]);
        v1 = sar(((adc >> 3) - (t1 << 1)) * t2, 11);
        d = (adc >> 4) - t1;
        v2 = sar(sar(d * d, 12) * t3, 14);
        t_fine = v1 + v2;
        c.value = sar(t_fine * 32'd5 + 32'd128, 8);
      end
      FUNC_PRESS: begin
        p1 = {16'd0, cal_regs[REG_PRESS_FIRST][15:0]};
        p2 = sext16(cal_regs[REG_PRESS_FIRST][31:16]);
        p3 = sext16(cal_regs[REG_PRESS_FIRST][47:32]);
        p4 = sext16(cal_regs[REG_PRESS_MID][15:0]);
        p5 = sext16(cal_regs[REG_PRESS_MID][31:16]);
        p6 = sext16(cal_regs[REG_PRESS_MID][47:32]);
        p7 = sext16(cal_regs[REG_PRESS_LAST][15:0]);
        p8 = sext16(cal_regs[REG_PRESS_LAST][31:16]);
        p9 = sext16(cal_regs[REG_PRESS_LAST][47:32]);
        v1 = sar(t_fine, 1) - 32'd64000;
        q = sar(v1, 2);
        v2 = sar(q * q, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = sar(v2, 2) + (p4 << 16);
        v1 = sar(sar(p3 * sar(q * q, 13), 3) + sar(p2 * v1, 1), 18);
        v1 = sar((32'd32768 + v1) * p1, 15);
        if (v1 == 0) begin
          c.zdiv = 1'b1;
        end else begin
          p = ((32'd1048576 - adc) - sar(v2, 12)) * 32'd3125;
          if (p < 32'h8000_0000) p = (p << 1) / v1;
          else p = (p / v1) * 32'd2;
          v1 = sar(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
          v2 = sar((p >> 2) * p8, 13);
          c.value = p + sar(v1 + v2 + p7, 4);
        end
      end
      FUNC_HUM: begin
        h1 = {24'd0, cal_regs[REG_HUM_FIRST][7:0]};
        h2 = sext16(cal_regs[REG_HUM_FIRST][23:8]);
        h3 = {24'd0, cal_regs[REG_HUM_FIRST][31:24]};
        h4 = {20'd0, cal_regs[REG_HUM_SECOND][11:0]};
        h5 = {20'd0, cal_regs[REG_HUM_SECOND][23:12]};
        h6 = {{24{cal_regs[REG_HUM_SECOND][31]}}, cal_regs[REG_HUM_SECOND][31:24]};
        v = t_fine - 32'd76800;
        a = sar((adc << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
        b = sar(sar(v * h6, 10) * (sar(v * h3, 11) + 32'd32768), 10);
        b = sar((b + 32'd2097152) * h2 + 32'd8192, 14);
        v = a * b;
        s = sar(v, 15);
        v = v - sar(sar(s * s, 7) * h1, 4);
        if (v[31]) v = 0;
        else if (v > 32'd419430400) v = 32'd419430400;
        c.value = v >> 12;
      end
      default: ;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: bursts of items with random gaps; expectation formed on accept.
  // ---------------------------------------------------------------------
  int  burst_left = 0;
  int  gap_left = 0;
  bit  hold_input = 0;   // sender pause until drained

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_comps.push_back(compensate({func_t'(in_if.func), in_if.raw_reading}));
        void'(pending_readings.pop_front());
      end
      if (in_if.valid && !in_if.ready) begin
        // keep offering the same item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (hold_input || pending_readings.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        // head of the queue is the next item once the accepted one is gone
        in_if.valid <= 1'b1;
        in_if.func <= pending_readings[0].func;
        in_if.raw_reading <= pending_readings[0].raw;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 6);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver stall pattern plus one long hold-off; monitor and checker.
  // ---------------------------------------------------------------------
  bit stall_free = 0;
  int long_hold = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_if.ready <= 1'b0;
    end else if (stall_free) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h", what, got, want);
  endtask

  int idle_cycles = 0;

  always @(posedge clk) begin
    comp_t want;
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (expected_comps.size() == 0) begin
          report("unexpected result", out_if.compensated, 0);
        end else begin
          want = expected_comps.pop_front();
          if (out_if.compensated !== want.value)
            report("compensated", out_if.compensated, want.value);
          if (out_if.zero_divisor !== want.zdiv)
            report("zero_divisor", out_if.zero_divisor, want.zdiv);
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG);
        $display("tb_sensor_thp_compensation_unit NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Configuration writes (only while idle).
  // ---------------------------------------------------------------------
  task automatic cfg_write(logic [2:0] idx, logic [47:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    // indexes past the last register are dropped by the unit
    if (idx <= 3'(REG_HUM_SECOND))
      cal_regs[idx] = (idx >= 3'(REG_HUM_FIRST)) ? {16'd0, val[31:0]} : val;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_readings.size() != 0 || in_if.valid || expected_comps.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_reading(func_t f, logic [19:0] raw);
    reading_t r;
    r.func = f;
    r.raw = raw;
    pending_readings.push_back(r);
    case (f)
      FUNC_TEMP: n_temp++;
      FUNC_PRESS: n_press++;
      FUNC_HUM: n_hum++;
      default: n_none++;
    endcase
  endtask

  // Realistic calibration set keeps pressure and humidity out of the
  // degenerate paths most of the time.
  task automatic load_typical();
    cfg_write(REG_TEMP_CAL, {16'd50, 16'd26435, 16'd27504});
    cfg_write(REG_PRESS_FIRST, {16'hF3D0, 16'hD6D0, 16'd36477});
    cfg_write(REG_PRESS_MID, {16'hFFF9, 16'hFFC6, 16'd2855});
    cfg_write(REG_PRESS_LAST, {16'h1770, 16'hC5F8, 16'hFFF6});
    cfg_write(REG_HUM_FIRST, {16'd0, 8'd0, 16'd362, 8'd75});
    cfg_write(REG_HUM_SECOND, {16'd0, 8'd30, 12'd50, 12'd320});
  endtask

  task automatic load_random();
    for (int i = 0; i < 8; i++)
      cfg_write(3'(i), 48'({$urandom, $urandom}));
  endtask

  // random mix of temperature, pressure, humidity and unused-selector readings
  task automatic random_readings(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: queue_reading(FUNC_TEMP, 20'($urandom_range(380000, 620000)));
        3, 4, 5: queue_reading(FUNC_PRESS, 20'($urandom_range(250000, 450000)));
        6, 7:    queue_reading(FUNC_HUM, 20'($urandom_range(20000, 40000)));
        8:       queue_reading(func_t'($urandom_range(0, 2)),
                               20'($urandom_range(0, 20'hFFFFF)));
        default: queue_reading(func_t'($urandom_range(0, 3)), 20'($urandom));
      endcase
    end
  endtask

  initial begin
    cfg_if.valid = 0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    in_if.valid = 0;
    in_if.func = FUNC_TEMP;
    in_if.raw_reading = '0;
    out_if.ready = 0;
    for (int i = 0; i < 6; i++) cal_regs[i] = '0;
    t_fine = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero calibration: zero divisor on pressure, every selector
    queue_reading(FUNC_PRESS, 20'h00000);
    queue_reading(FUNC_TEMP, 20'hFFFFF);
    queue_reading(FUNC_HUM, 20'hFFFFF);
    queue_reading(FUNC_NONE, 20'hFFFFF);
    wait_drained();

    // all-ones calibration extremes, wide humidity reading wraps
    for (int i = 0; i < 6; i++) cfg_write(3'(i), 48'hFFFF_FFFF_FFFF);
    queue_reading(FUNC_TEMP, 20'h00000);
    queue_reading(FUNC_PRESS, 20'hFFFFF);
    queue_reading(FUNC_HUM, 20'h00000);
    queue_reading(FUNC_HUM, 20'hFFFFF);
    queue_reading(FUNC_TEMP, 20'hFFFFF);
    queue_reading(FUNC_PRESS, 20'h00000);
    wait_drained();

    // typical calibration: normal readings and humidity clamps at both ends
    load_typical();
    queue_reading(FUNC_TEMP, 20'd519888);
    queue_reading(FUNC_PRESS, 20'd415148);
    queue_reading(FUNC_HUM, 20'd30000);
    queue_reading(FUNC_HUM, 20'h00000);
    queue_reading(FUNC_HUM, 20'h0FFFF);
    queue_reading(FUNC_PRESS, 20'h00000);
    queue_reading(FUNC_PRESS, 20'hFFFFF);
    queue_reading(FUNC_NONE, 20'h55555);
    queue_reading(FUNC_HUM, 20'hAAAAA);
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    long_hold = 400;
    random_readings(30);
    wait_drained();

    random_readings(150);
    wait_drained();

    // random calibration set, including reserved register indexes ignored by RTL
    load_random();
    random_readings(60);
    wait_drained();

    // no-stall stretch with back-to-back offers
    load_typical();
    stall_free = 1;
    random_readings(60);
    wait_drained();
    stall_free = 0;

    // traffic, then the sender pauses until every expected result is back
    random_readings(20);
    repeat (100) @(posedge clk);
    hold_input = 1;
    while (in_if.valid || expected_comps.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    hold_input = 0;
    random_readings(100);
    wait_drained();

    $display("covered %0d temperature, %0d pressure, %0d humidity, %0d unused-selector items",
             n_temp, n_press, n_hum, n_none);
    $display("%0d results checked across zero, all-ones, typical and random calibration",
             n_results);
    if (errors == 0) begin
      $display("tb_sensor_thp_compensation_unit OK");
    end else begin
      $display("tb_sensor_thp_compensation_unit NOT OK");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sthp_pkg.sv
rtl/core/sthp_in_if.sv
rtl/core/sthp_out_if.sv
rtl/core/sthp_cfg_if.sv
rtl/core/sthp_mul.sv
rtl/core/sthp_div.sv
rtl/core/sensor_thp_compensation_unit.sv
dv/sthp_tb_if.sv
dv/tb_sensor_thp_compensation_unit.sv
